### hw/rtl/ilir_pkg.sv
package ilir_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int CMD_W        = 2;
    localparam int POS_W        = 8;
    localparam int STATUS_W     = 2;
    localparam int CNT_OUT_W    = 5;
    localparam int CNT_MAX_W    = 9;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_INSERT = 2'd2,
        CMD_REMOVE = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef struct packed {
        logic                 ins;
        logic                 rem;
        logic [CNT_MAX_W-1:0] pos;
    } t_cell_ctrl;

endpackage

### hw/rtl/ilir_req_if.sv
interface ilir_req_if
    import ilir_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] item_value;

    modport source (output valid, output cmd, output position, output item_value,
                    input ready);
    modport sink   (input valid, input cmd, input position, input item_value,
                    output ready);
endinterface

### hw/rtl/ilir_rsp_if.sv
interface ilir_rsp_if
    import ilir_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] popped_value;
    logic [CNT_OUT_W-1:0]     entry_count;

    modport source (output valid, output status, output popped_value,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input popped_value,
                    input entry_count, output ready);
endinterface

### hw/rtl/ilir_cell.sv
module ilir_cell
    import ilir_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic              i_clk,
    input  t_cell_ctrl        i_ctrl,
    input  logic [DATA_W-1:0] i_word,
    input  logic [DATA_W-1:0] i_left,
    input  logic [DATA_W-1:0] i_right,
    output logic [DATA_W-1:0] o_value
);

    localparam logic [CNT_MAX_W-1:0] IDX = CNT_MAX_W'(INDEX);

    logic [DATA_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins) begin
            if (IDX > i_ctrl.pos) begin
                r_value <= i_left;
            end else if (IDX == i_ctrl.pos) begin
                r_value <= i_word;
            end
        end else if (i_ctrl.rem) begin
            if (IDX >= i_ctrl.pos) begin
                r_value <= i_right;
            end
        end
    end

    assign o_value = r_value;

endmodule

### hw/rtl/indexed_list_insert_remove_unit.sv
// Ordered list of up to CAPACITY signed 32-bit words, held in a row of cells.
// Each request pushes, pops, inserts at a position or removes at a position;
// the cells shift all later entries up or down together in the cycle the
// request is accepted, and a new request is taken each cycle while the
// response register is free or being drained.
// Every request returns one response: status, the popped word (zero unless a
// pop succeeds) and the entry count afterwards (low 5 bits). A failed request
// leaves the list unchanged. Entries are not cleared at reset; only entries
// below the count are ever read.
module indexed_list_insert_remove_unit
    import ilir_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ilir_req_if.sink   i_req,
    ilir_rsp_if.source o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic                 r_out_valid;
    t_status              r_status;
    t_status              n_status;
    logic [DATA_W-1:0]    r_popped;
    logic [DATA_W-1:0]    n_popped;
    logic [CNT_OUT_W-1:0] r_entry_count;

    logic                 in_fire;
    logic                 full;
    logic                 empty;
    logic [CNT_MAX_W-1:0] cnt_ext;
    logic [CNT_MAX_W-1:0] pos_ext;
    t_cell_ctrl           op_ctrl;
    t_cell_ctrl           cell_ctrl;
    logic [DATA_W-1:0]    cell_value [CAPACITY];

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign in_fire     = i_req.valid && i_req.ready;

    assign full    = (r_count == CW'(CAPACITY));
    assign empty   = (r_count == '0);
    assign cnt_ext = CNT_MAX_W'(r_count);
    assign pos_ext = CNT_MAX_W'(i_req.position);

    always_comb begin
        n_status    = ST_OK;
        n_popped    = '0;
        n_count     = r_count;
        op_ctrl.ins = 1'b0;
        op_ctrl.rem = 1'b0;
        op_ctrl.pos = pos_ext;
        unique case (t_cmd'(i_req.cmd))
            CMD_PUSH: begin
                op_ctrl.pos = cnt_ext;
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    op_ctrl.ins = 1'b1;
                    n_count     = r_count + CW'(1);
                end
            end
            CMD_POP: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_popped = cell_value[IW'(r_count - CW'(1))];
                    n_count  = r_count - CW'(1);
                end
            end
            CMD_INSERT: begin
                if (pos_ext > cnt_ext) begin
                    n_status = ST_RANGE;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    op_ctrl.ins = 1'b1;
                    n_count     = r_count + CW'(1);
                end
            end
            CMD_REMOVE: begin
                if (pos_ext >= cnt_ext) begin
                    n_status = ST_RANGE;
                end else begin
                    op_ctrl.rem = 1'b1;
                    n_count     = r_count - CW'(1);
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_comb begin
        cell_ctrl     = op_ctrl;
        cell_ctrl.ins = op_ctrl.ins && in_fire;
        cell_ctrl.rem = op_ctrl.rem && in_fire;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] left_value;
        logic [DATA_W-1:0] right_value;

        if (g == 0) begin : g_first
            assign left_value = i_req.item_value;
        end else begin : g_mid_l
            assign left_value = cell_value[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_value = cell_value[g];
        end else begin : g_mid_r
            assign right_value = cell_value[g+1];
        end

        ilir_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (cell_ctrl),
            .i_word  (i_req.item_value),
            .i_left  (left_value),
            .i_right (right_value),
            .o_value (cell_value[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_status      <= n_status;
            r_popped      <= n_popped;
            r_entry_count <= CNT_OUT_W'(n_count);
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.popped_value = r_popped;
    assign o_rsp.entry_count  = r_entry_count;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("count exceeds capacity");

    a_fire_gives_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_out_valid)
        else $error("accepted request produced no response");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && t_cmd'(i_req.cmd) == CMD_PUSH && n_status == ST_OK
        |=> r_count == $past(r_count) + CW'(1))
        else $error("successful push did not grow the list");

    a_fail_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && n_status != ST_OK |=> r_count == $past(r_count))
        else $error("failed request changed the count");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status == ST_EMPTY |-> r_entry_count == '0 && r_popped == '0)
        else $error("empty response with nonzero fields");
`endif

endmodule

### dv/indexed_list_insert_remove_unit_tb.sv
`timescale 1ns / 1ps

module indexed_list_insert_remove_unit_tb;
    import ilir_pkg::*;

    localparam int LIST_DEPTH     = CAPACITY_DEF;
    localparam int RANDOM_ITEMS   = 1800;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct {
        t_status                  status;
        logic signed [DATA_W-1:0] popped;
        logic [CNT_OUT_W-1:0]     count;
    } list_rsp_t;

    typedef struct {
        t_cmd                     cmd;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] word;
        int                       reps;
        bit                       typed;
        list_rsp_t                rsp;
    } stim_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ilir_req_if req_if ();
    ilir_rsp_if rsp_if ();

    indexed_list_insert_remove_unit #(
        .CAPACITY(LIST_DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic signed [DATA_W-1:0] list_words [LIST_DEPTH];
    int                       list_count = 0;
    list_rsp_t                expected_responses [$];
    stim_row_t                directed_rows [$];
    bit                       req_typed;
    list_rsp_t                req_typed_rsp;
    bit                       quiet_mode = 1'b0;
    int                       error_count = 0;
    int                       stall_cycles = 0;

    function automatic list_rsp_t apply_list_request(t_cmd op, logic [POS_W-1:0] pos,
                                                     logic signed [DATA_W-1:0] word);
        list_rsp_t r;
        r.status = ST_OK;
        r.popped = '0;
        case (op)
            CMD_PUSH: begin
                if (list_count >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    list_words[list_count] = word;
                    list_count++;
                end
            end
            CMD_POP: begin
                if (list_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    list_count--;
                    r.popped = list_words[list_count];
                end
            end
            CMD_INSERT: begin
                if (int'(pos) > list_count) begin
                    r.status = ST_RANGE;
                end else if (list_count >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = list_count; i > int'(pos); i--) begin
                        list_words[i] = list_words[i-1];
                    end
                    list_words[pos] = word;
                    list_count++;
                end
            end
            default: begin
                if (int'(pos) >= list_count) begin
                    r.status = ST_RANGE;
                end else begin
                    for (int i = int'(pos); i + 1 < list_count; i++) begin
                        list_words[i] = list_words[i+1];
                    end
                    list_count--;
                end
            end
        endcase
        r.count = list_count[CNT_OUT_W-1:0];
        return r;
    endfunction

    function automatic void add_row(t_cmd cmd, int pos, logic signed [DATA_W-1:0] word, int reps,
                                    bit typed, t_status st, int cnt);
        stim_row_t row;
        row.cmd        = cmd;
        row.pos        = pos[POS_W-1:0];
        row.word       = word;
        row.reps       = reps;
        row.typed      = typed;
        row.rsp.status = st;
        row.rsp.popped = '0;
        row.rsp.count  = cnt[CNT_OUT_W-1:0];
        directed_rows.push_back(row);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(t_cmd cmd, logic [POS_W-1:0] pos, logic signed [DATA_W-1:0] word,
                                bit typed, list_rsp_t rsp);
        int gap;
        gap = quiet_mode ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.cmd        = cmd;
        req_if.position   = pos;
        req_if.item_value = word;
        req_typed         = typed;
        req_typed_rsp     = rsp;
        req_if.valid      = 1'b1;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : response_check
        list_rsp_t want;
        bit        progress;
        if (i_rst_n) begin
            progress = 1'b0;
            if (req_if.valid && req_if.ready) begin
                want = apply_list_request(t_cmd'(req_if.cmd), req_if.position,
                                          req_if.item_value);
                if (req_typed) begin
                    want = req_typed_rsp;
                end
                expected_responses.push_back(want);
                progress = 1'b1;
            end
            if (rsp_if.valid && rsp_if.ready) begin
                progress = 1'b1;
                if (expected_responses.size() == 0) begin
                    error_count++;
                    $display("time %0t: unexpected response, expected none, got status %0d count %0d",
                             $time, rsp_if.status, rsp_if.entry_count);
                end else begin
                    want = expected_responses.pop_front();
                    if (rsp_if.status !== want.status) begin
                        error_count++;
                        $display("time %0t: status expected %0d got %0d",
                                 $time, want.status, rsp_if.status);
                    end
                    if (rsp_if.popped_value !== want.popped) begin
                        error_count++;
                        $display("time %0t: popped_value expected %0d got %0d",
                                 $time, want.popped, rsp_if.popped_value);
                    end
                    if (rsp_if.entry_count !== want.count) begin
                        error_count++;
                        $display("time %0t: entry_count expected %0d got %0d",
                                 $time, want.count, rsp_if.entry_count);
                    end
                end
            end
            stall_cycles = progress ? 0 : stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin : response_drain
        int stall;
        rsp_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = quiet_mode ? 0 : $urandom_range(0, 3);
            if (stall != 0) begin
                rsp_if.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_if.ready = 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        list_rsp_t                none;
        t_cmd                     cmd;
        int                       pos;
        int                       pick;
        logic signed [DATA_W-1:0] word;
        bit                       filling;

        none.status       = ST_OK;
        none.popped       = '0;
        none.count        = '0;
        req_if.valid      = 1'b0;
        req_if.cmd        = CMD_PUSH;
        req_if.position   = '0;
        req_if.item_value = '0;
        req_typed         = 1'b0;
        req_typed_rsp     = none;
        i_rst_n           = 1'b0;

        add_row(CMD_POP,    0,   32'sd0,         1,  1, ST_EMPTY, 0);
        add_row(CMD_REMOVE, 0,   32'sd0,         1,  1, ST_RANGE, 0);
        add_row(CMD_INSERT, 255, 32'sd0,         1,  1, ST_RANGE, 0);
        add_row(CMD_INSERT, 0,   32'h8000_0000,  1,  1, ST_OK,    1);
        add_row(CMD_PUSH,   0,   32'h7FFF_FFFF,  1,  1, ST_OK,    2);
        add_row(CMD_INSERT, 1,   32'sd0,         1,  0, ST_OK,    0);
        add_row(CMD_INSERT, 3,   32'hFFFF_FFFF,  1,  0, ST_OK,    0);
        add_row(CMD_REMOVE, 4,   32'sd0,         1,  1, ST_RANGE, 4);
        add_row(CMD_REMOVE, 1,   32'sd0,         1,  0, ST_OK,    0);
        add_row(CMD_POP,    0,   32'sd0,         1,  0, ST_OK,    0);
        add_row(CMD_REMOVE, 255, 32'sd0,         1,  1, ST_RANGE, 2);
        add_row(CMD_PUSH,   0,   32'h1000_0000,  14, 0, ST_OK,    0);
        add_row(CMD_PUSH,   0,   32'sd5,         1,  1, ST_FULL,  16);
        add_row(CMD_INSERT, 16,  32'sd6,         1,  1, ST_FULL,  16);
        add_row(CMD_INSERT, 17,  32'sd7,         1,  1, ST_RANGE, 16);
        add_row(CMD_REMOVE, 15,  32'sd0,         1,  0, ST_OK,    0);
        add_row(CMD_INSERT, 0,   32'sh5555_AAAA, 1,  0, ST_OK,    0);
        add_row(CMD_POP,    0,   32'sd0,         1,  0, ST_OK,    0);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[r]) begin
            for (int k = 0; k < directed_rows[r].reps; k++) begin
                send_request(directed_rows[r].cmd, directed_rows[r].pos,
                             directed_rows[r].word + k, directed_rows[r].typed,
                             directed_rows[r].rsp);
            end
        end

        filling = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 0) begin
                quiet_mode = ($urandom_range(0, 3) == 0);
            end
            // turn around at the ends, but linger there now and then
            if ((list_count >= LIST_DEPTH || list_count == 0) && $urandom_range(0, 3) == 0) begin
                filling = (list_count == 0);
            end else if ($urandom_range(0, 49) == 0) begin
                filling = !filling;
            end
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                cmd = filling ? CMD_PUSH : CMD_POP;
            end else if (pick < 70) begin
                cmd = filling ? CMD_INSERT : CMD_REMOVE;
            end else if (pick < 85) begin
                cmd = filling ? CMD_POP : CMD_PUSH;
            end else begin
                cmd = filling ? CMD_REMOVE : CMD_INSERT;
            end
            case ($urandom_range(0, 9))
                7:       pos = list_count;
                8:       pos = $urandom_range(0, 255);
                9:       pos = 0;
                default: begin
                    if (cmd == CMD_REMOVE && list_count > 0) begin
                        pos = $urandom_range(0, list_count - 1);
                    end else begin
                        pos = $urandom_range(0, list_count);
                    end
                end
            endcase
            case ($urandom_range(0, 15))
                0:       word = 32'h8000_0000;
                1:       word = 32'h7FFF_FFFF;
                2:       word = 32'hFFFF_FFFF;
                3:       word = 32'sd0;
                default: word = $urandom();
            endcase
            send_request(cmd, pos[POS_W-1:0], word, 1'b0, none);
        end

        req_if.valid = 1'b0;
        while (expected_responses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
